>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FSMB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define FSMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/fsmb_pkg.sv
package fsmb_pkg;

  // Request opcodes; codes six and seven act as stats
  typedef enum logic [2:0] {
    FN_BEGIN   = 3'd0,
    FN_FINISH  = 3'd1,
    FN_TAKE    = 3'd2,
    FN_RELEASE = 3'd3,
    FN_BUMP    = 3'd4,
    FN_STATS   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_INVALID  = 3'd1,
    STS_STALE    = 3'd2,
    STS_MISMATCH = 3'd3,
    STS_NO_SLOT  = 3'd4,
    STS_NO_FRAME = 3'd5,
    STS_IGNORED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    SL_EMPTY    = 2'd0,
    SL_WRITING  = 2'd1,
    SL_COMPLETE = 2'd2
  } slot_st_t;

  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned OUT_DATA_W = 248;

  // Registered request, size check already resolved
  typedef struct packed {
    func_t        func;
    logic [31:0]  frame_generation;
    logic         bytes_zero;
    logic         size_ok;
    logic [35:0]  byte_count;
    logic [63:0]  frame_number;
    logic [3:0]   slot_index;
  } req_t;

  typedef struct packed {
    status_t      status;
    logic [3:0]   result_slot;
    logic [63:0]  latest_frame_number;
    logic [31:0]  current_generation;
    logic [31:0]  published_count;
    logic [31:0]  dropped_count;
    logic [31:0]  leased_count;
    logic [4:0]   complete_slots;
    logic [4:0]   held_slots;
    logic [35:0]  max_frame_bytes;
  } res_t;

endpackage

>>> hw/rtl/fsmb_in_stage.sv
module fsmb_in_stage
  import fsmb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [2:0]           in_tuser,
  input  logic                 fire,
  output logic                 req_valid,
  output req_t                 req
);

  logic        valid_r;
  req_t        req_r;
  req_t        req_nxt;
  logic [15:0] height;
  logic [19:0] stride;
  logic [35:0] prod;

  assign in_tready = !valid_r || fire;
  assign req_valid = valid_r;
  assign req       = req_r;

  // Unpack the transfer and resolve the size check before it is registered
  assign height = in_tdata[47:32];
  assign stride = in_tdata[67:48];
  assign prod   = 36'(height) * 36'(stride);

  always_comb begin
    req_nxt.func             = func_t'(in_tuser);
    req_nxt.frame_generation = in_tdata[31:0];
    req_nxt.byte_count       = in_tdata[103:68];
    req_nxt.frame_number     = in_tdata[167:104];
    req_nxt.slot_index       = in_tdata[171:168];
    req_nxt.bytes_zero       = (in_tdata[103:68] == 36'd0);
    req_nxt.size_ok          = (stride != 20'd0) && (prod == in_tdata[103:68]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= req_nxt;
    end
  end

endmodule

>>> hw/rtl/fsmb_core.sv
`include "assert_macros.svh"

module fsmb_core
  import fsmb_pkg::*;
#(
  parameter int unsigned SLOTS = 3
) (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  output res_t res
);

  slot_st_t    st_r     [SLOTS];
  slot_st_t    st_nxt   [SLOTS];
  logic [7:0]  rd_r     [SLOTS];
  logic [7:0]  rd_nxt   [SLOTS];
  logic [63:0] fno_r    [SLOTS];
  logic [63:0] fno_nxt  [SLOTS];
  logic [63:0] stamp_r  [SLOTS];
  logic [63:0] stamp_nxt[SLOTS];
  logic [35:0] bytes_r  [SLOTS];
  logic [35:0] bytes_nxt[SLOTS];
  logic [31:0] gen_r, gen_nxt;
  logic [63:0] ctr_r, ctr_nxt;
  logic [31:0] pub_r, pub_nxt;
  logic [31:0] drop_r, drop_nxt;
  logic [31:0] lease_r, lease_nxt;

  logic [SLOTS-1:0] hit;
  logic [SLOTS-1:0] wr_sel;
  logic [SLOTS-1:0] take_sel;
  logic [SLOTS-1:0] compl_cur;
  logic             wr_any;
  logic [3:0]       wr_idx;
  logic [3:0]       take_idx;
  logic [63:0]      take_fno;

  // Pick a slot to write: first free empty one, else oldest unread complete one
  always_comb begin
    logic             seen;
    logic             ok;
    logic [SLOTS-1:0] empty_free;
    logic [SLOTS-1:0] empty_sel;
    logic [SLOTS-1:0] cand;
    logic [SLOTS-1:0] old_sel;
    seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      empty_free[i] = (st_r[i] == SL_EMPTY) && (rd_r[i] == 8'd0);
      cand[i]       = (st_r[i] == SL_COMPLETE) && (rd_r[i] == 8'd0);
      compl_cur[i]  = (st_r[i] == SL_COMPLETE);
      hit[i]        = (req.slot_index == 4'(i));
      empty_sel[i]  = empty_free[i] && !seen;
      seen          = seen || empty_free[i];
    end
    for (int i = 0; i < SLOTS; i++) begin
      ok = cand[i];
      for (int j = 0; j < SLOTS; j++) begin
        if (j < i && cand[j] && !(stamp_r[i] < stamp_r[j])) ok = 1'b0;
        if (j > i && cand[j] && !(stamp_r[i] <= stamp_r[j])) ok = 1'b0;
      end
      old_sel[i] = ok;
    end
    wr_sel = seen ? empty_sel : old_sel;
    wr_any = |wr_sel;
    wr_idx = 4'd0;
    for (int i = 0; i < SLOTS; i++) begin
      if (wr_sel[i]) wr_idx = wr_idx | 4'(i);
    end
  end

  // Pick the complete slot with the highest frame number, lowest index on a tie
  always_comb begin
    logic ok;
    for (int i = 0; i < SLOTS; i++) begin
      ok = compl_cur[i];
      for (int j = 0; j < SLOTS; j++) begin
        if (j < i && compl_cur[j] && !(fno_r[i] > fno_r[j])) ok = 1'b0;
        if (j > i && compl_cur[j] && !(fno_r[i] >= fno_r[j])) ok = 1'b0;
      end
      take_sel[i] = ok;
    end
    take_idx = 4'd0;
    take_fno = 64'd0;
    for (int i = 0; i < SLOTS; i++) begin
      if (take_sel[i]) begin
        take_idx = take_idx | 4'(i);
        take_fno = take_fno | fno_r[i];
      end
    end
  end

  // Apply the request to the slot table and build the result
  always_comb begin
    logic             ok;
    logic [SLOTS-1:0] compl_n;
    logic [63:0]      max_fno;
    logic [35:0]      max_b;
    logic [4:0]       n_compl;
    logic [4:0]       n_held;
    st_nxt    = st_r;
    rd_nxt    = rd_r;
    fno_nxt   = fno_r;
    stamp_nxt = stamp_r;
    bytes_nxt = bytes_r;
    gen_nxt   = gen_r;
    ctr_nxt   = ctr_r;
    pub_nxt   = pub_r;
    drop_nxt  = drop_r;
    lease_nxt = lease_r;
    res.status              = STS_OK;
    res.result_slot         = 4'd0;
    res.latest_frame_number = 64'd0;

    case (req.func)
      FN_BEGIN: begin
        if (req.bytes_zero) begin
          res.status = STS_INVALID;
        end else if (req.frame_generation != gen_r) begin
          res.status = STS_STALE;
          drop_nxt   = drop_r + 32'd1;
        end else if (!req.size_ok) begin
          res.status = STS_MISMATCH;
          drop_nxt   = drop_r + 32'd1;
        end else if (!wr_any) begin
          res.status = STS_NO_SLOT;
          drop_nxt   = drop_r + 32'd1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (wr_sel[i]) begin
              st_nxt[i]    = SL_WRITING;
              fno_nxt[i]   = req.frame_number;
              bytes_nxt[i] = req.byte_count;
            end
          end
          res.result_slot = wr_idx;
        end
      end
      FN_FINISH: begin
        ok = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (hit[i] && st_r[i] == SL_WRITING) begin
            ok           = 1'b1;
            st_nxt[i]    = SL_COMPLETE;
            stamp_nxt[i] = ctr_r;
          end
        end
        if (ok) begin
          ctr_nxt = ctr_r + 64'd1;
          pub_nxt = pub_r + 32'd1;
        end else begin
          res.status = STS_IGNORED;
        end
      end
      FN_TAKE: begin
        if (!(|compl_cur)) begin
          res.status = STS_NO_FRAME;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (take_sel[i] && rd_r[i] != 8'hFF) rd_nxt[i] = rd_r[i] + 8'd1;
          end
          lease_nxt               = lease_r + 32'd1;
          res.result_slot         = take_idx;
          res.latest_frame_number = take_fno;
        end
      end
      FN_RELEASE: begin
        ok = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (hit[i] && rd_r[i] != 8'd0) begin
            ok        = 1'b1;
            rd_nxt[i] = rd_r[i] - 8'd1;
          end
        end
        if (!ok) res.status = STS_IGNORED;
      end
      FN_BUMP: begin
        gen_nxt = gen_r + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          if (rd_r[i] == 8'd0) begin
            st_nxt[i]    = SL_EMPTY;
            fno_nxt[i]   = 64'd0;
            bytes_nxt[i] = 36'd0;
          end
        end
      end
      default: begin
        // stats: filled in below from the unchanged table
      end
    endcase

    // Summaries over the table as it stands after the request
    n_compl = 5'd0;
    n_held  = 5'd0;
    max_fno = 64'd0;
    max_b   = 36'd0;
    for (int i = 0; i < SLOTS; i++) begin
      compl_n[i] = (st_nxt[i] == SL_COMPLETE);
      n_compl    = n_compl + 5'(compl_n[i]);
      n_held     = n_held + 5'(rd_nxt[i] != 8'd0);
    end
    for (int i = 0; i < SLOTS; i++) begin
      ok = compl_n[i];
      for (int j = 0; j < SLOTS; j++) begin
        if (compl_n[j] && !(fno_nxt[i] >= fno_nxt[j])) ok = 1'b0;
      end
      if (ok) max_fno = max_fno | fno_nxt[i];
      ok = compl_n[i];
      for (int j = 0; j < SLOTS; j++) begin
        if (compl_n[j] && !(bytes_nxt[i] >= bytes_nxt[j])) ok = 1'b0;
      end
      if (ok) max_b = max_b | bytes_nxt[i];
    end

    // Stats and the unused codes above it report the largest frame number
    if (req.func >= FN_STATS) begin
      res.latest_frame_number = max_fno;
    end
    res.current_generation = gen_nxt;
    res.published_count    = pub_nxt;
    res.dropped_count      = drop_nxt;
    res.leased_count       = lease_nxt;
    res.complete_slots     = n_compl;
    res.held_slots         = n_held;
    res.max_frame_bytes    = max_b;
  end

  // Hold slot control and totals; advance on each request taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i] <= SL_EMPTY;
        rd_r[i] <= 8'd0;
      end
      gen_r   <= 32'd0;
      ctr_r   <= 64'd0;
      pub_r   <= 32'd0;
      drop_r  <= 32'd0;
      lease_r <= 32'd0;
    end else if (fire) begin
      st_r    <= st_nxt;
      rd_r    <= rd_nxt;
      gen_r   <= gen_nxt;
      ctr_r   <= ctr_nxt;
      pub_r   <= pub_nxt;
      drop_r  <= drop_nxt;
      lease_r <= lease_nxt;
    end
  end

  // Slot payload; only read for slots that have been written
  always_ff @(posedge clk) begin
    if (fire) begin
      fno_r   <= fno_nxt;
      stamp_r <= stamp_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  `FSMB_ASSERT_SAME(a_wr_sel_onehot, 1'b1, $onehot0(wr_sel))
  `FSMB_ASSERT_SAME(a_take_found, fire && req.func == FN_TAKE && (|compl_cur), res.status == STS_OK)
  `FSMB_ASSERT_NEXT(a_finish_counts, fire && req.func == FN_FINISH && res.status == STS_OK, pub_r == $past(pub_r) + 32'd1)
  `FSMB_ASSERT_NEXT(a_bump_gen, fire && req.func == FN_BUMP, gen_r == $past(gen_r) + 32'd1)

endmodule

>>> hw/rtl/fsmb_out_stage.sv
module fsmb_out_stage
  import fsmb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  res_t                  res,
  output logic                  out_free,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic valid_r;
  res_t res_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;

  // Pack fields from the lowest bit up, zero pad to whole bytes
  assign out_tdata = {3'd0,
                      res_r.max_frame_bytes,
                      res_r.held_slots,
                      res_r.complete_slots,
                      res_r.leased_count,
                      res_r.dropped_count,
                      res_r.published_count,
                      res_r.current_generation,
                      res_r.latest_frame_number,
                      res_r.result_slot,
                      res_r.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

endmodule

>>> hw/rtl/frame_slot_mailbox.sv
// Frame slot mailbox: tracks a few frame buffer slots shared by one producer
// and several readers, one request per input transfer, one result per request.
// Input channel: in_tuser carries the opcode (begin publish, finish publish,
// take latest, release, bump generation, stats); in_tdata carries the frame
// fields. Output channel: status, chosen or leased slot, frame number and the
// block's counters and slot summaries after the request.
// A request passes from the input register through the slot table logic
// into the result register, which drives out_tdata.
// Throughput: one request per cycle while out_tready is high; the slot table
// is read and updated combinationally between the two registers, so
// back-to-back requests see each other's effects in order.
// Reset: every slot empty with no readers, generation, publish stamp counter
// and all totals zero. No clearing pass is needed.
// Stall: while out_tready is low the result holds; one more request may wait
// in the input register, after which in_tready drops.
module frame_slot_mailbox
  import fsmb_pkg::*;
#(
  parameter int unsigned SLOTS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // frame_generation, frame_height, row_stride, byte_count, frame_number,
  // slot_index
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, result_slot, latest_frame_number, current_generation,
  // published_count, dropped_count, leased_count, complete_slots, held_slots,
  // max_frame_bytes
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic req_valid;
  req_t req;
  res_t res;
  logic out_free;
  logic fire;

  // Advance a request when the result register can take it
  assign fire = req_valid && out_free;

  fsmb_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fire      (fire),
    .req_valid (req_valid),
    .req       (req)
  );

  fsmb_core #(
    .SLOTS (SLOTS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req),
    .res   (res)
  );

  fsmb_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> sim/fsmb_result_check.sv
`timescale 1ns / 100ps

// Watches both stream channels, keeps its own copy of the slot table and
// compares each result transfer with the oldest expected one.
module fsmb_result_check
  import fsmb_pkg::*;
#(
  parameter int unsigned SLOTS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]            in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int unsigned           mismatch_count,
  output int unsigned           pending_count
);

  typedef struct {
    status_t      status;
    logic [3:0]   slot;
    logic [63:0]  frame_no;
    logic [31:0]  gen;
    logic [31:0]  published;
    logic [31:0]  dropped;
    logic [31:0]  leased;
    logic [4:0]   n_complete;
    logic [4:0]   n_held;
    logic [35:0]  max_bytes;
  } mbx_result_t;

  // Shadow slot table and totals
  slot_st_t    slot_phase     [SLOTS];
  logic [7:0]  slot_holds     [SLOTS];
  logic [63:0] slot_fnum      [SLOTS];
  logic [63:0] slot_pub_stamp [SLOTS];
  logic [35:0] slot_size      [SLOTS];
  logic [31:0] cur_gen;
  logic [63:0] next_stamp;
  logic [31:0] n_published;
  logic [31:0] n_dropped;
  logic [31:0] n_leased;

  mbx_result_t expected_results[$];

  // Apply one request to the shadow table and return the result it must give
  function automatic mbx_result_t apply_request(logic [2:0] op, logic [IN_DATA_W-1:0] d);
    logic [31:0] fgen;
    logic [15:0] fh;
    logic [19:0] fs;
    logic [35:0] fb;
    logic [63:0] fn;
    logic [3:0]  idx;
    logic [63:0] best;
    logic [63:0] max_fnum;
    int          pick;
    mbx_result_t r;
    fgen = d[31:0];
    fh   = d[47:32];
    fs   = d[67:48];
    fb   = d[103:68];
    fn   = d[167:104];
    idx  = d[171:168];
    r.status     = STS_OK;
    r.slot       = '0;
    r.frame_no   = '0;
    r.n_complete = '0;
    r.n_held     = '0;
    r.max_bytes  = '0;
    max_fnum     = '0;
    best         = '0;
    pick         = -1;

    case (op)
      FN_BEGIN: begin
        if (fb == '0) begin
          r.status = STS_INVALID;
        end else if (fgen != cur_gen) begin
          r.status = STS_STALE;
          n_dropped++;
        end else if (fs == '0 || fb != {20'd0, fh} * {16'd0, fs}) begin
          r.status = STS_MISMATCH;
          n_dropped++;
        end else begin
          // first free unread slot, else oldest complete unread slot
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && slot_phase[i] == SL_EMPTY && slot_holds[i] == 0) pick = i;
          if (pick < 0)
            for (int i = 0; i < SLOTS; i++)
              if (slot_phase[i] == SL_COMPLETE && slot_holds[i] == 0 &&
                  (pick < 0 || slot_pub_stamp[i] < best)) begin
                pick = i;
                best = slot_pub_stamp[i];
              end
          if (pick < 0) begin
            r.status = STS_NO_SLOT;
            n_dropped++;
          end else begin
            slot_phase[pick] = SL_WRITING;
            slot_fnum[pick]  = fn;
            slot_size[pick]  = fb;
            r.slot           = 4'(pick);
          end
        end
      end
      FN_FINISH: begin
        if (idx < SLOTS && slot_phase[idx] == SL_WRITING) begin
          slot_phase[idx]     = SL_COMPLETE;
          slot_pub_stamp[idx] = next_stamp;
          next_stamp++;
          n_published++;
        end else begin
          r.status = STS_IGNORED;
        end
      end
      FN_TAKE: begin
        // highest frame number wins, lowest index on a tie
        for (int i = 0; i < SLOTS; i++)
          if (slot_phase[i] == SL_COMPLETE && (pick < 0 || slot_fnum[i] > best)) begin
            pick = i;
            best = slot_fnum[i];
          end
        if (pick < 0) begin
          r.status = STS_NO_FRAME;
        end else begin
          if (slot_holds[pick] != 8'hFF) slot_holds[pick]++;
          n_leased++;
          r.slot     = 4'(pick);
          r.frame_no = best;
        end
      end
      FN_RELEASE: begin
        if (idx < SLOTS && slot_holds[idx] != 0) slot_holds[idx]--;
        else r.status = STS_IGNORED;
      end
      FN_BUMP: begin
        cur_gen++;
        for (int i = 0; i < SLOTS; i++)
          if (slot_holds[i] == 0) begin
            slot_phase[i] = SL_EMPTY;
            slot_fnum[i]  = '0;
            slot_size[i]  = '0;
          end
      end
      default: ;
    endcase

    // Summaries after the request
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_phase[i] == SL_COMPLETE) begin
        r.n_complete++;
        if (slot_size[i] > r.max_bytes) r.max_bytes = slot_size[i];
        if (slot_fnum[i] > max_fnum) max_fnum = slot_fnum[i];
      end
      if (slot_holds[i] != 0) r.n_held++;
    end
    if (op >= FN_STATS) r.frame_no = max_fnum;
    r.gen       = cur_gen;
    r.published = n_published;
    r.dropped   = n_dropped;
    r.leased    = n_leased;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Track transfers on both channels
  always @(posedge clk) begin
    mbx_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_phase[i]     = SL_EMPTY;
        slot_holds[i]     = '0;
        slot_fnum[i]      = '0;
        slot_pub_stamp[i] = '0;
        slot_size[i]      = '0;
      end
      cur_gen        = '0;
      next_stamp     = '0;
      n_published    = '0;
      n_dropped      = '0;
      n_leased       = '0;
      mismatch_count = 0;
      expected_results.delete();
    end else begin
      // retire first so a result never matches a request taken at the same edge
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_tdata[2:0]));
          check_field("result_slot", 64'(want.slot), 64'(out_tdata[6:3]));
          check_field("latest_frame_number", want.frame_no, out_tdata[70:7]);
          check_field("current_generation", 64'(want.gen), 64'(out_tdata[102:71]));
          check_field("published_count", 64'(want.published), 64'(out_tdata[134:103]));
          check_field("dropped_count", 64'(want.dropped), 64'(out_tdata[166:135]));
          check_field("leased_count", 64'(want.leased), 64'(out_tdata[198:167]));
          check_field("complete_slots", 64'(want.n_complete), 64'(out_tdata[203:199]));
          check_field("held_slots", 64'(want.n_held), 64'(out_tdata[208:204]));
          check_field("max_frame_bytes", 64'(want.max_bytes), 64'(out_tdata[244:209]));
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(in_tuser, in_tdata));
    end
    pending_count = expected_results.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fsmb_pkg::*;

  localparam int unsigned MBX_SLOTS  = 3;
  localparam int          IDLE_LIMIT = 4000;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [2:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int unsigned           mismatch_count;
  int unsigned           pending_count;

  logic [31:0] gen_now    = '0;
  int          burst_left = 1;
  int          idle_cycles = 0;
  int          stall_phase = 0;
  int          stall_mode  = 0;

  frame_slot_mailbox #(.SLOTS(MBX_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  fsmb_result_check #(.SLOTS(MBX_SLOTS)) result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: pick a new random stall mode each time the stall phase runs out
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(16, 80);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= stall_phase[2];
    endcase
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("frame_slot_mailbox regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request, hold it until the transfer, then pace the burst
  task automatic send_request(input logic [2:0] op, input logic [31:0] g,
                              input logic [15:0] h, input logic [19:0] s,
                              input logic [35:0] b, input logic [63:0] fnum,
                              input logic [3:0] idx);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, idx, fnum, b, s, h, g};
    in_tuser  <= op;
    if (op == FN_BUMP) gen_now = gen_now + 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [63:0] rand_frame_no();
    if ($urandom_range(0, 1) == 0) return 64'($urandom_range(0, 15));
    return {$urandom(), $urandom()};
  endfunction

  // Mostly a real slot, sometimes any index
  function automatic int pick_slot();
    if ($urandom_range(0, 6) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, MBX_SLOTS - 1);
  endfunction

  // Non-publish request with noise in the unused fields
  task automatic send_plain(input logic [2:0] op, input logic [3:0] idx);
    send_request(op, $urandom(), 16'($urandom()), 20'($urandom()),
                 {4'($urandom()), 32'($urandom())}, {$urandom(), $urandom()}, idx);
  endtask

  task automatic send_frame(input logic [31:0] g, input logic [15:0] h,
                            input logic [19:0] s, input logic [35:0] b,
                            input logic [63:0] fnum);
    send_request(FN_BEGIN, g, h, s, b, fnum, 4'($urandom()));
  endtask

  // One random request; publishes are mostly well formed
  task automatic send_random();
    logic [15:0] h;
    logic [19:0] s;
    logic [35:0] prod;
    int          sel;
    int          kind;
    sel  = $urandom_range(0, 99);
    kind = $urandom_range(0, 9);
    h = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 16))
                                    : 16'($urandom_range(1, 16'hFFFF));
    s = ($urandom_range(0, 1) == 0) ? 20'($urandom_range(1, 64))
                                    : 20'($urandom_range(1, 20'hFFFFF));
    prod = {20'd0, h} * {16'd0, s};
    if (sel < 28) begin
      case (kind)
        0: send_frame(gen_now, h, s, 36'd0, rand_frame_no());
        1: send_frame(gen_now + $urandom_range(1, 32'hFFFFFFFF), h, s, prod, rand_frame_no());
        2: send_frame(gen_now, h, 20'd0, prod, rand_frame_no());
        3: send_frame(gen_now, h, s, prod + 36'($urandom_range(1, 1000)), rand_frame_no());
        default: send_frame(gen_now, h, s, prod, rand_frame_no());
      endcase
    end else begin
      if (sel < 50)      send_plain(FN_FINISH, 4'(pick_slot()));
      else if (sel < 68) send_plain(FN_TAKE, 4'($urandom()));
      else if (sel < 83) send_plain(FN_RELEASE, 4'(pick_slot()));
      else if (sel < 88) send_plain(FN_BUMP, 4'($urandom()));
      else               send_plain(3'($urandom_range(FN_STATS, 7)), 4'($urandom()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, bad sizes, fill, overflow, lease, reuse, bump
    send_plain(FN_STATS, 4'd0);
    send_plain(FN_TAKE, 4'd0);
    send_plain(FN_RELEASE, 4'd0);
    send_plain(FN_FINISH, 4'd0);
    send_plain(FN_FINISH, 4'd15);
    send_frame(gen_now, 16'hFFFF, 20'hFFFFF, 36'd0, 64'd1);
    send_frame(32'hFFFFFFFF, 16'd1, 20'd1, 36'd1, 64'd1);
    send_frame(gen_now, 16'd4, 20'd0, 36'd64, 64'd1);
    send_frame(gen_now, 16'd4, 20'd16, 36'd65, 64'd1);
    send_frame(gen_now, 16'hFFFF, 20'hFFFFF, {20'd0, 16'hFFFF} * {16'd0, 20'hFFFFF},
               64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(gen_now, 16'd1, 20'd1, 36'd1, 64'd0);
    send_frame(gen_now, 16'd2, 20'd3, 36'd6, 64'd5);
    send_frame(gen_now, 16'd1, 20'd1, 36'd1, 64'd7);
    send_plain(FN_FINISH, 4'd0);
    send_plain(FN_FINISH, 4'd1);
    send_plain(FN_FINISH, 4'd2);
    send_plain(FN_TAKE, 4'd0);
    send_frame(gen_now, 16'd1, 20'd1, 36'd1, 64'd5);
    send_plain(FN_FINISH, 4'd1);
    send_plain(FN_BUMP, 4'd0);
    send_frame(gen_now - 1, 16'd1, 20'd1, 36'd1, 64'd3);
    send_plain(FN_RELEASE, 4'd0);
    send_plain(FN_RELEASE, 4'd3);
    send_plain(3'd6, 4'd0);
    send_plain(3'd7, 4'd0);

    repeat (900) send_random();

    // Saturate a reader count with a long run of leases
    send_plain(FN_BUMP, 4'd0);
    send_frame(gen_now, 16'd8, 20'd8, 36'd64, rand_frame_no());
    for (int i = 0; i < MBX_SLOTS; i++) send_plain(FN_FINISH, 4'(i));
    repeat (270) send_plain(FN_TAKE, 4'($urandom()));

    repeat (150) send_random();
    in_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("frame_slot_mailbox regression: pass");
    end else begin
      $display("frame_slot_mailbox regression: fail");
    end
    $finish;
  end

endmodule
